// ===== hdl/iprtl_pkg.sv =====
// shared constants and types for the ip range table lookup
package iprtl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = 32;

    localparam logic [1:0] CMD_WRITE_RANGE  = 2'd0;
    localparam logic [1:0] CMD_WRITE_PREFIX = 2'd1;
    localparam logic [1:0] CMD_LOOKUP       = 2'd2;
    localparam logic [1:0] CMD_CLEAR        = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX  = 2'd1;
    localparam logic [1:0] ST_BAD_PREFIX = 2'd2;

    localparam logic [5:0] MAX_PREFIX = 6'd32;
    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // one table row as held in the ram
    typedef struct packed {
        logic [31:0]       payload;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] first;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/iprtl_ram.sv =====
// generic single write port ram with registered read
module iprtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ip_range_table_lookup.sv =====
// ip range table lookup: table ram, sequencer, scan compare and config register
//
// Holds 64 IPv4 ranges (first, last, 32-bit value) in one ram with a single
// read port. A write-range or write-prefix word stores its entry in the cycle
// it is accepted and returns its status from the done state; a clear word
// empties the table at once through per-entry valid bits (no sweep after
// reset or clear) and also answers from the done state. A lookup reads and
// compares one entry per cycle, from index 0 upward, over the first n entries,
// n being entries_in_use capped at 64, and stops at the first match. One
// word is worked on at a time; s_tready is high only while the block is idle.
// Empty entries read as the range 0..0 with value 0.
module ip_range_table_lookup (
    input  logic         aclk,
    input  logic         aresetn,
    // command words
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, range_start, range_end, prefix_base, prefix_length,
    // entry_value, lookup_address, zero pad
    input  logic [175:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // found, matched_value, matched_index, zero pad
    output logic [39:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // input fields
    logic [1:0]                      command;
    logic [iprtl_pkg::IDX_W-1:0]     entry_index;
    logic [31:0]                     range_start;
    logic [31:0]                     range_end;
    logic [31:0]                     prefix_base;
    logic [5:0]                      prefix_length;
    logic [31:0]                     entry_value;
    logic [31:0]                     lookup_address;

    state_t                          state_reg, state_next;
    logic [iprtl_pkg::CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                            cmp_pend_reg, cmp_pend_next;
    logic [iprtl_pkg::IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [31:0]                     addr_reg, addr_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic                            res_found_reg, res_found_next;
    logic [31:0]                     res_value_reg, res_value_next;
    logic [iprtl_pkg::IDX_W-1:0]     res_index_reg, res_index_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [1:0]                      m_tuser_reg, m_tuser_next;
    logic [39:0]                     m_tdata_reg, m_tdata_next;
    logic [iprtl_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                            rd_valid_reg;
    logic [6:0]                      eiu_reg;

    logic [iprtl_pkg::CNT_W-1:0]     n_eff;
    logic                            in_accept;
    logic                            issue;
    logic                            hit;
    logic [31:0]                     host_mask;
    logic [31:0]                     pfx_first;
    logic [31:0]                     pfx_last;
    logic [1:0]                      wr_status;
    logic                            cfg_write;

    logic                            ram_we;
    logic [iprtl_pkg::IDX_W-1:0]     ram_raddr;
    iprtl_pkg::entry_t               ram_wdata;
    logic [iprtl_pkg::ENTRY_W-1:0]   ram_rdata;
    iprtl_pkg::entry_t               cur_entry;

    assign command        = s_tuser;
    assign entry_index    = s_tdata[5:0];
    assign range_start    = s_tdata[37:6];
    assign range_end      = s_tdata[69:38];
    assign prefix_base    = s_tdata[101:70];
    assign prefix_length  = s_tdata[107:102];
    assign entry_value    = s_tdata[139:108];
    assign lookup_address = s_tdata[171:140];

    assign n_eff = (eiu_reg > iprtl_pkg::DEPTH_CNT) ? iprtl_pkg::DEPTH_CNT : eiu_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // shifting by 32 leaves no host bits, by 0 covers the whole space
    assign host_mask = iprtl_pkg::ALL_ONES >> prefix_length;
    assign pfx_first = prefix_base & ~host_mask;
    assign pfx_last  = pfx_first | host_mask;

    always_comb begin
        if (command == iprtl_pkg::CMD_WRITE_PREFIX && prefix_length > iprtl_pkg::MAX_PREFIX) begin
            wr_status = iprtl_pkg::ST_BAD_PREFIX;
        end else if ({1'b0, entry_index} >= n_eff) begin
            wr_status = iprtl_pkg::ST_BAD_INDEX;
        end else begin
            wr_status = iprtl_pkg::ST_OK;
        end
    end

    always_comb begin
        ram_wdata.payload = entry_value;
        if (command == iprtl_pkg::CMD_WRITE_PREFIX) begin
            ram_wdata.first = pfx_first;
            ram_wdata.last  = pfx_last;
        end else begin
            ram_wdata.first = range_start;
            ram_wdata.last  = range_end;
        end
    end

    assign ram_raddr = scan_idx_reg[iprtl_pkg::IDX_W-1:0];

    iprtl_ram #(
        .WIDTH (iprtl_pkg::ENTRY_W),
        .DEPTH (iprtl_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (entry_index),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an entry never written since reset or clear reads as all zero
    assign cur_entry = rd_valid_reg ? iprtl_pkg::entry_t'(ram_rdata) : '0;

    assign issue = (state_reg == S_SCAN) && (scan_idx_reg < n_eff);
    assign hit   = cmp_pend_reg && (cur_entry.first <= addr_reg) && (addr_reg <= cur_entry.last);

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_pend_next   = cmp_pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    res_status_next = iprtl_pkg::ST_OK;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_index_next  = '0;
                    case (command)
                        iprtl_pkg::CMD_LOOKUP: begin
                            addr_next     = lookup_address;
                            scan_idx_next = '0;
                            cmp_pend_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        iprtl_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            res_status_next = wr_status;
                            if (wr_status == iprtl_pkg::ST_OK) begin
                                ram_we                  = 1'b1;
                                valid_next[entry_index] = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read of entry k overlaps the compare of entry k-1
                cmp_pend_next = issue;
                cmp_idx_next  = scan_idx_reg[iprtl_pkg::IDX_W-1:0];
                if (issue) begin
                    scan_idx_next = scan_idx_reg + iprtl_pkg::CNT_W'(1);
                end
                if (hit) begin
                    res_found_next = 1'b1;
                    res_value_next = cur_entry.payload;
                    res_index_next = cmp_idx_reg;
                    state_next     = S_DONE;
                end else if (scan_idx_reg == n_eff) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {1'b0, res_index_reg, res_value_reg, res_found_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_idx_reg <= '0;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            eiu_reg      <= 7'd64;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_pend_reg <= cmp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            if (cfg_write && (paddr[2] == 1'b0)) begin
                eiu_reg <= pwdata[6:0];
            end
        end
        cmp_idx_reg    <= cmp_idx_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
        rd_valid_reg   <= valid_reg[ram_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, eiu_reg} : 32'd0;

    // a match is only ever reported with an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tuser == iprtl_pkg::ST_OK)
        else $error("found set on a result whose status is not ok");

    // the scan never runs past the active entries
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> scan_idx_reg <= n_eff)
        else $error("scan index beyond active entry count");

    // a clear has emptied every entry in the cycle after it is accepted
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == iprtl_pkg::CMD_CLEAR |=> valid_reg == '0)
        else $error("entries still valid after clear");

    // a failed write leaves the table ram untouched
    a_no_bad_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> wr_status == iprtl_pkg::ST_OK && in_accept)
        else $error("table written on a rejected word");

endmodule

// ===== bench/tb_ip_range_table_lookup.sv =====
// self-checking testbench for the ip range table lookup: stream driver, predictor and scoreboard
`timescale 1ns / 100ps

module tb_ip_range_table_lookup;

    localparam logic [2:0] REG_IN_USE_ADDR = 3'd0;
    localparam logic [2:0] REG_SPARE_ADDR  = 3'd4;
    localparam int         STALL_LIMIT     = 3000;
    localparam int         PHASE_WORDS     = 200;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  idx;
        logic [31:0] rstart;
        logic [31:0] rend;
        logic [31:0] pbase;
        logic [5:0]  plen;
        logic [31:0] val;
        logic [31:0] addr;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value;
        logic [5:0]  index;
    } result_t;

    // predicted table contents and the results still owed by the block
    class range_scoreboard;
        logic [31:0] first_tab [iprtl_pkg::TABLE_DEPTH];
        logic [31:0] last_tab  [iprtl_pkg::TABLE_DEPTH];
        logic [31:0] value_tab [iprtl_pkg::TABLE_DEPTH];
        logic [6:0]  in_use;
        result_t     due [$];
        int          mismatches;
        int          checked;
        int          hits;
        int          err_status;

        function new();
            wipe_table();
            in_use = iprtl_pkg::DEPTH_CNT;
        endfunction

        function void wipe_table();
            foreach (first_tab[i]) begin
                first_tab[i] = '0;
                last_tab[i]  = '0;
                value_tab[i] = '0;
            end
        endfunction

        function int span_n();
            return (in_use > iprtl_pkg::DEPTH_CNT) ? iprtl_pkg::TABLE_DEPTH : int'(in_use);
        endfunction

        function void set_in_use(logic [31:0] v);
            in_use = v[6:0];
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void note_word(cmd_word_t w);
            result_t     r;
            logic [31:0] lo;
            logic [31:0] hi;
            logic [31:0] host_mask;
            int          n;
            r = '0;
            n = span_n();
            case (w.cmd)
                iprtl_pkg::CMD_WRITE_RANGE, iprtl_pkg::CMD_WRITE_PREFIX: begin
                    lo = w.rstart;
                    hi = w.rend;
                    if (w.cmd == iprtl_pkg::CMD_WRITE_PREFIX) begin
                        if (w.plen > iprtl_pkg::MAX_PREFIX) begin
                            r.status = iprtl_pkg::ST_BAD_PREFIX;
                        end else if (w.plen == iprtl_pkg::MAX_PREFIX) begin
                            lo = w.pbase;
                            hi = w.pbase;
                        end else if (w.plen == 6'd0) begin
                            lo = '0;
                            hi = iprtl_pkg::ALL_ONES;
                        end else begin
                            host_mask = iprtl_pkg::ALL_ONES >> w.plen;
                            lo = w.pbase & ~host_mask;
                            hi = lo | host_mask;
                        end
                    end
                    if (r.status == iprtl_pkg::ST_OK && int'(w.idx) >= n)
                        r.status = iprtl_pkg::ST_BAD_INDEX;
                    if (r.status == iprtl_pkg::ST_OK) begin
                        first_tab[w.idx] = lo;
                        last_tab[w.idx]  = hi;
                        value_tab[w.idx] = w.val;
                    end
                end
                iprtl_pkg::CMD_LOOKUP: begin
                    // lowest matching index wins
                    for (int i = 0; i < n; i++) begin
                        if (first_tab[i] <= w.addr && w.addr <= last_tab[i]) begin
                            r.found = 1'b1;
                            r.value = value_tab[i];
                            r.index = i[5:0];
                            break;
                        end
                    end
                end
                default: begin
                    wipe_table();
                end
            endcase
            due.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            checked++;
            if (due.size() == 0) begin
                flag($sformatf("unexpected result: status %0d found %0d value %h index %0d",
                               got.status, got.found, got.value, got.index));
                return;
            end
            exp = due.pop_front();
            if (exp.found)
                hits++;
            if (exp.status != iprtl_pkg::ST_OK)
                err_status++;
            if (got.status !== exp.status || got.found !== exp.found ||
                    got.value !== exp.value || got.index !== exp.index)
                flag($sformatf({"result %0d mismatch: exp status %0d found %0d value %h ",
                                "index %0d, got status %0d found %0d value %h index %0d"},
                               checked, exp.status, exp.found, exp.value, exp.index,
                               got.status, got.found, got.value, got.index));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    range_scoreboard sb = new();
    int  kind_count [4];
    int  reg_writes;
    int  idle_cycles;
    bit  calm_tx;
    bit  calm_rx;
    int  rx_stall;

    ip_range_table_lookup uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [175:0] pack_word(cmd_word_t w);
        return {4'b0, w.addr, w.val, w.plen, w.pbase, w.rend, w.rstart, w.idx};
    endfunction

    function automatic cmd_word_t noise_word(logic [1:0] cmd);
        cmd_word_t w;
        w.cmd    = cmd;
        w.idx    = 6'($urandom);
        w.rstart = $urandom;
        w.rend   = $urandom;
        w.pbase  = $urandom;
        w.plen   = 6'($urandom);
        w.val    = $urandom;
        w.addr   = $urandom;
        return w;
    endfunction

    // lookups aimed at the edges, just outside and inside of ranges already held
    function automatic logic [31:0] aim_address();
        int          i;
        int          n;
        int          r;
        logic [31:0] lo;
        logic [31:0] hi;
        n = sb.span_n();
        i = (n > 0 && $urandom_range(99) < 85)
            ? $urandom_range(0, n - 1)
            : $urandom_range(0, iprtl_pkg::TABLE_DEPTH - 1);
        lo = sb.first_tab[i];
        hi = sb.last_tab[i];
        r = $urandom_range(99);
        if (r < 20)
            return lo;
        if (r < 35)
            return hi;
        if (r < 45)
            return lo - 32'd1;
        if (r < 55)
            return hi + 32'd1;
        if (r < 80 && hi >= lo) begin
            if (hi - lo == iprtl_pkg::ALL_ONES)
                return $urandom;
            return lo + ($urandom % (hi - lo + 32'd1));
        end
        if (r < 85)
            return '0;
        if (r < 88)
            return iprtl_pkg::ALL_ONES;
        return $urandom;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        n;
        int        r;
        int        s;
        r = $urandom_range(99);
        if (r < 30)
            w = noise_word(iprtl_pkg::CMD_WRITE_RANGE);
        else if (r < 55)
            w = noise_word(iprtl_pkg::CMD_WRITE_PREFIX);
        else if (r < 97)
            w = noise_word(iprtl_pkg::CMD_LOOKUP);
        else
            w = noise_word(iprtl_pkg::CMD_CLEAR);
        n = sb.span_n();
        if (n > 0 && $urandom_range(99) < 85)
            w.idx = 6'($urandom_range(0, n - 1));
        case (w.cmd)
            iprtl_pkg::CMD_WRITE_RANGE: begin
                s = $urandom_range(99);
                if (s < 10)
                    w.rstart = $urandom_range(0, 15);
                if (s < 70)
                    w.rend = w.rstart + $urandom_range(0, 255);
                else if (s < 85)
                    w.rend = w.rstart;
            end
            iprtl_pkg::CMD_WRITE_PREFIX: begin
                if ($urandom_range(99) < 85)
                    w.plen = 6'($urandom_range(0, 32));
                else
                    w.plen = 6'($urandom_range(33, 63));
            end
            iprtl_pkg::CMD_LOOKUP: begin
                if ($urandom_range(99) < 75)
                    w.addr = aim_address();
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic issue(cmd_word_t w);
        int gap;
        s_tdata  <= pack_word(w);
        s_tuser  <= w.cmd;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_word(w);
        kind_count[w.cmd]++;
        @(negedge aclk);
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if ($urandom_range(99) < 2)
            calm_tx = ~calm_tx;
    endtask

    task automatic put_range(logic [5:0] idx, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] val);
        cmd_word_t w;
        w = noise_word(iprtl_pkg::CMD_WRITE_RANGE);
        w.idx    = idx;
        w.rstart = lo;
        w.rend   = hi;
        w.val    = val;
        issue(w);
    endtask

    task automatic put_prefix(logic [5:0] idx, logic [31:0] base, logic [5:0] len,
                              logic [31:0] val);
        cmd_word_t w;
        w = noise_word(iprtl_pkg::CMD_WRITE_PREFIX);
        w.idx   = idx;
        w.pbase = base;
        w.plen  = len;
        w.val   = val;
        issue(w);
    endtask

    task automatic look(logic [31:0] addr);
        cmd_word_t w;
        w = noise_word(iprtl_pkg::CMD_LOOKUP);
        w.addr = addr;
        issue(w);
    endtask

    // only touched once the block has drained; called at a falling edge with s_tvalid low
    task automatic set_register(logic [2:0] addr, logic [31:0] value);
        while (sb.due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == REG_IN_USE_ADDR)
            sb.set_in_use(value);
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        paddr   <= REG_IN_USE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== {25'b0, sb.in_use})
            sb.flag($sformatf("entries_in_use readback: exp %0d got %0d", sb.in_use, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random back-pressure with calm stretches
    initial begin
        m_tready = 1'b0;
        rx_stall = 0;
        calm_rx  = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
                rx_stall = calm_rx ? 0 : pick_gap();
            end
            if ($urandom_range(99) < 2)
                calm_rx = ~calm_rx;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.found  = m_tdata[0];
            got.value  = m_tdata[32:1];
            got.index  = m_tdata[38:33];
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("block stalled for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.due.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned phase_cfg [9];
        phase_cfg = '{1, 64, 0, 16, 127, 33, 2, 100, 64};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = iprtl_pkg::CMD_WRITE_RANGE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = REG_IN_USE_ADDR;
        pwdata   = '0;
        calm_tx  = 1'b0;
        idle_cycles = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: cleared table, each prefix form, errors, overlap, empty range
        look(32'h0000_0000);
        look(32'h0000_0001);
        put_range(6'd0, 32'h0a00_0000, 32'h0a00_00ff, 32'hdead_beef);
        put_prefix(6'd1, 32'hc0a8_014d, 6'd24, 32'h1111_2222);
        put_prefix(6'd2, 32'h0808_0808, 6'd32, 32'hffff_ffff);
        put_prefix(6'd3, 32'h1234_5678, 6'd0, 32'h0000_0003);
        put_prefix(6'd4, 32'h0000_0000, 6'd33, 32'h5555_5555);
        put_prefix(6'd63, 32'hffff_ffff, 6'd63, 32'haaaa_aaaa);
        put_prefix(6'd6, 32'hffff_ffff, 6'd1, 32'h0000_0006);
        put_prefix(6'd7, 32'h7fff_ffff, 6'd31, 32'h0000_0007);
        put_range(6'd5, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0005);
        look(32'h0a00_0080);
        look(32'hc0a8_01ff);
        look(32'h0808_0808);
        look(32'hffff_ffff);
        put_range(6'd63, 32'hffff_ffff, 32'hffff_ffff, 32'h6363_6363);
        put_range(6'd0, 32'h0000_0000, 32'hffff_ffff, 32'h0000_00aa);
        look(32'h8000_0000);
        issue(noise_word(iprtl_pkg::CMD_CLEAR));
        look(32'h0000_0000);
        look(32'hffff_ffff);
        s_tvalid <= 1'b0;

        // junk in the upper bits of the write data, then an unmapped address
        set_register(REG_IN_USE_ADDR, 32'hffff_ff84);
        set_register(REG_SPARE_ADDR, 32'h0000_0011);
        put_range(6'd4, 32'h0000_0100, 32'h0000_01ff, 32'h0000_0004);
        put_prefix(6'd50, 32'h0102_0304, 6'd40, 32'h0000_0032);
        put_range(6'd3, 32'h0000_0100, 32'h0000_01ff, 32'h0000_0033);
        look(32'h0000_0150);
        s_tvalid <= 1'b0;

        foreach (phase_cfg[p]) begin
            set_register(REG_IN_USE_ADDR, phase_cfg[p]);
            repeat (PHASE_WORDS)
                issue(random_word());
            s_tvalid <= 1'b0;
        end

        while (sb.due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d range writes, %0d prefix writes, %0d lookups (%0d hits), %0d clears",
                 kind_count[iprtl_pkg::CMD_WRITE_RANGE], kind_count[iprtl_pkg::CMD_WRITE_PREFIX],
                 kind_count[iprtl_pkg::CMD_LOOKUP], sb.hits, kind_count[iprtl_pkg::CMD_CLEAR]);
        $display("%0d results checked, %0d error statuses, %0d register writes, %0d mismatches",
                 sb.checked, sb.err_status, reg_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/iprtl_pkg.sv
hdl/iprtl_ram.sv
hdl/ip_range_table_lookup.sv
bench/tb_ip_range_table_lookup.sv
